/* hdl/assert_macros.svh */
// Assertion macros included by otp_code_validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

/* hdl/otpv_pkg.sv */
// Types and constants of the one-time-password validator.
package otpv_pkg;
   localparam int unsigned WORD_W = 32;
   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5C;
   localparam logic [31:0] IPAD_WORD = {4{IPAD_BYTE}};
   localparam logic [31:0] OPAD_WORD = {4{OPAD_BYTE}};

   localparam logic [1:0] CSR_SECRET_LOW  = 2'd0;
   localparam logic [1:0] CSR_SECRET_HIGH = 2'd1;

   localparam logic [1:0] BLK_IPAD  = 2'd0;
   localparam logic [1:0] BLK_MSG   = 2'd1;
   localparam logic [1:0] BLK_OPAD  = 2'd2;
   localparam logic [1:0] BLK_DIGEST = 2'd3;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_DIV    = 8'b00000010,
      ST_LOAD   = 8'b00000100,
      ST_ROUND  = 8'b00001000,
      ST_FOLD   = 8'b00010000,
      ST_TRUNC  = 8'b00100000,
      ST_MOD    = 8'b01000000,
      ST_OUT    = 8'b10000000
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] chain_init(input logic [2:0] i);
      case (i)
         3'd0: chain_init = 32'h67452301;
         3'd1: chain_init = 32'hEFCDAB89;
         3'd2: chain_init = 32'h98BADCFE;
         3'd3: chain_init = 32'h10325476;
         default: chain_init = 32'hC3D2E1F0;
      endcase
   endfunction
endpackage

/* hdl/otp_code_validator.sv */
// Top level of the HOTP/TOTP one-time-password validator.
// The req_ channel carries one beat per check: func (0 = HOTP, 1 = TOTP),
// moving_factor and candidate_code. The rsp_ channel returns one beat per
// request with computed_code and code_matches. The csr_ port writes the
// 80-bit secret (index 0 = low 64 bits, index 1 = high 16 bits); the user
// must write it only while idle, which the block itself does not enforce.
// One request is worked at a time. The HMAC-SHA1 takes four compressions.
// Each compression is a load step, sixteen rounds on the block words, 64
// rounds on the schedule (the schedule window sits in a 16-word RAM and each
// round reads t-3, t-8, t-14 and t-16 over four read slots) and a fold step.
// Truncation, a reciprocal modulo and the output state follow. TOTP mode
// first divides by the time step with a reciprocal multiply.
// A request is taken only when the block is idle; the result waits in its
// output register for as long as rsp_stall holds, and a new request is
// accepted in the cycle after that beat has left. Reset clears the secret
// and returns the controller to idle; no clearing pass is needed.
module otp_code_validator #(
   parameter int unsigned TIME_STEP_MS = 30000,
   parameter int unsigned CODE_MODULUS = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_moving_factor,
   input  logic [19:0] req_candidate_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_code_matches,
   output logic [19:0] rsp_computed_code,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import otpv_pkg::*;
`include "assert_macros.svh"

   // Reciprocals for the divisions by constants; each estimate is at most one low.
   localparam logic [63:0] TS_RECIP = 64'((128'd1 << 64) / 128'(TIME_STEP_MS));
   localparam logic [31:0] TS_WORD  = 32'(TIME_STEP_MS);
   localparam logic [31:0] CM_RECIP = 32'((64'd1 << 32) / 64'(CODE_MODULUS));
   localparam logic [31:0] CM_WORD  = 32'(CODE_MODULUS);

   logic [63:0] sec_lo_ff;
   logic [15:0] sec_hi_ff;
   state_type   st_ff, st_in;
   logic [63:0] ctr_ff, ctr_in;
   logic [63:0] rem_ff, rem_in;      // product and remainder of the divisions
   logic [65:0] acc_ff, acc_in;      // quotient estimate
   logic [6:0]  dcnt_ff, dcnt_in;
   logic [19:0] cand_ff, cand_in;
   logic [31:0] ch_ff [5];
   logic [31:0] ch_in [5];
   logic [31:0] wk_ff [5];
   logic [31:0] wk_in [5];
   logic [31:0] dig_ff [5];          // inner digest
   logic [31:0] dig_in [5];
   logic [6:0]  rnd_ff, rnd_in;
   logic [1:0]  blk_ff, blk_in;
   logic [1:0]  slot_ff, slot_in;    // schedule read slot within a round
   logic [31:0] wacc_ff, wacc_in;
   logic [31:0] bin_ff, bin_in;
   logic [19:0] code_ff, code_in;
   logic        match_ff, match_in;
   logic        rv_ff, rv_in;

   logic        ram_we;
   logic [3:0]  ram_wa, ram_ra;
   logic [31:0] ram_wd, ram_rd;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   otpv_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_lo_ff <= '0;
         sec_hi_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SECRET_LOW:  sec_lo_ff <= csr_data;
            CSR_SECRET_HIGH: sec_hi_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Message word t of the current block, for t below sixteen.
   function automatic logic [31:0] blk_word(input logic [1:0] b, input logic [3:0] t,
                                            input logic [63:0] lo, input logic [15:0] hi,
                                            input logic [63:0] ctr,
                                            input logic [31:0] dg0, input logic [31:0] dg1,
                                            input logic [31:0] dg2, input logic [31:0] dg3,
                                            input logic [31:0] dg4);
      logic [31:0] key;
      key = '0;
      case (t)
         4'd0: key = {hi, lo[63:48]};
         4'd1: key = lo[47:16];
         4'd2: key = {lo[15:0], 16'h0};
         default: key = '0;
      endcase
      case (b)
         BLK_IPAD: blk_word = key ^ IPAD_WORD;
         BLK_OPAD: blk_word = key ^ OPAD_WORD;
         BLK_MSG: begin
            case (t)
               4'd0: blk_word = ctr[63:32];
               4'd1: blk_word = ctr[31:0];
               4'd2: blk_word = 32'h80000000;
               4'd15: blk_word = 32'd576;
               default: blk_word = '0;
            endcase
         end
         default: begin
            case (t)
               4'd0: blk_word = dg0;
               4'd1: blk_word = dg1;
               4'd2: blk_word = dg2;
               4'd3: blk_word = dg3;
               4'd4: blk_word = dg4;
               4'd5: blk_word = 32'h80000000;
               4'd15: blk_word = 32'd672;
               default: blk_word = '0;
            endcase
         end
      endcase
   endfunction

   // One shared 32 by 32 multiplier for both divisions.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (st_ff == ST_DIV) begin
         case (dcnt_ff)
            7'd0: begin
               mul_a = ctr_ff[31:0]; mul_b = TS_RECIP[31:0];
            end
            7'd1: begin
               mul_a = ctr_ff[31:0]; mul_b = TS_RECIP[63:32];
            end
            7'd2: begin
               mul_a = ctr_ff[63:32]; mul_b = TS_RECIP[31:0];
            end
            7'd3: begin
               mul_a = ctr_ff[63:32]; mul_b = TS_RECIP[63:32];
            end
            7'd4: begin
               mul_a = acc_ff[31:0]; mul_b = TS_WORD;
            end
            default: begin
               mul_a = acc_ff[63:32]; mul_b = TS_WORD;
            end
         endcase
      end else if (st_ff == ST_MOD) begin
         if (dcnt_ff == 7'd0) begin
            mul_a = bin_ff; mul_b = CM_RECIP;
         end else begin
            mul_a = acc_ff[31:0]; mul_b = CM_WORD;
         end
      end
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   logic [31:0] w_cur, f_v, k_v, tmp_v;
   logic [63:0] dres;
   logic [31:0] dword;
   logic [3:0]  doff;
   logic [159:0] dflat;
   logic        is_sched;

   always_comb begin
      st_in = st_ff; ctr_in = ctr_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      cand_in = cand_ff; rnd_in = rnd_ff; blk_in = blk_ff; slot_in = slot_ff;
      wacc_in = wacc_ff; bin_in = bin_ff; code_in = code_ff;
      match_in = match_ff; rv_in = rv_ff; acc_in = acc_ff;
      for (int i = 0; i < 5; i++) begin
         ch_in[i] = ch_ff[i]; wk_in[i] = wk_ff[i]; dig_in[i] = dig_ff[i];
      end
      ram_we = 1'b0; ram_wa = rnd_ff[3:0]; ram_wd = '0; ram_ra = rnd_ff[3:0];
      is_sched = (rnd_ff >= 7'd16);
      w_cur = is_sched ? rotl(wacc_ff ^ ram_rd, 1)
                       : blk_word(blk_ff, rnd_ff[3:0], sec_lo_ff, sec_hi_ff, ctr_ff,
                                  dig_ff[0], dig_ff[1], dig_ff[2], dig_ff[3], dig_ff[4]);
      if (rnd_ff < 7'd20) begin
         f_v = (wk_ff[1] & wk_ff[2]) | (~wk_ff[1] & wk_ff[3]); k_v = 32'h5A827999;
      end else if (rnd_ff < 7'd40) begin
         f_v = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3]; k_v = 32'h6ED9EBA1;
      end else if (rnd_ff < 7'd60) begin
         f_v = (wk_ff[1] & wk_ff[2]) | (wk_ff[1] & wk_ff[3]) | (wk_ff[2] & wk_ff[3]);
         k_v = 32'h8F1BBCDC;
      end else begin
         f_v = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3]; k_v = 32'hCA62C1D6;
      end
      tmp_v = rotl(wk_ff[0], 5) + f_v + wk_ff[4] + k_v + w_cur;
      dres = ctr_ff - rem_ff;
      dflat = {ch_ff[0], ch_ff[1], ch_ff[2], ch_ff[3], ch_ff[4]};
      doff = ch_ff[4][3:0];
      dword = dflat[159 - 8*doff -: 32];

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               ctr_in = req_moving_factor;
               cand_in = req_candidate_code;
               rem_in = '0;
               dcnt_in = '0;
               blk_in = BLK_IPAD;
               st_in = req_func ? ST_DIV : ST_LOAD;
            end
         end
         ST_DIV: begin
            // The high half of factor times reciprocal is built from four partial
            // products; the low 32 bits are dropped once no carry can reach them.
            case (dcnt_ff) inside
               7'd0: acc_in = {34'd0, mul_p[63:32]};
               7'd1, 7'd2: acc_in = acc_ff + {2'd0, mul_p};
               7'd3: acc_in = {32'd0, acc_ff[65:32]} + {2'd0, mul_p};
               7'd4: rem_in = mul_p;
               7'd5: rem_in = rem_ff + {mul_p[31:0], 32'd0};
               default: begin
                  ctr_in = (dres >= {32'd0, TS_WORD}) ? acc_ff[63:0] + 64'd1
                                                       : acc_ff[63:0];
                  st_in = ST_LOAD;
               end
            endcase
            dcnt_in = dcnt_ff + 7'd1;
         end
         ST_LOAD: begin
            for (int i = 0; i < 5; i++) begin
               if (blk_ff == BLK_IPAD || blk_ff == BLK_OPAD) begin
                  ch_in[i] = chain_init(3'(i));
               end
               wk_in[i] = (blk_ff == BLK_IPAD || blk_ff == BLK_OPAD)
                          ? chain_init(3'(i)) : ch_ff[i];
            end
            rnd_in = '0; slot_in = '0; wacc_in = '0;
            ram_ra = 4'(7'd16 - 7'd3);
            st_in = ST_ROUND;
         end
         ST_ROUND: begin
            // From round sixteen on, slots 0..3 read t-3, t-8, t-14, t-16; read data
            // lands in the cycle after its address.
            if (!is_sched || slot_ff == 2'd3) begin
               ram_we = 1'b1; ram_wd = w_cur;
               wk_in[4] = wk_ff[3]; wk_in[3] = wk_ff[2];
               wk_in[2] = rotl(wk_ff[1], 30); wk_in[1] = wk_ff[0]; wk_in[0] = tmp_v;
               rnd_in = rnd_ff + 7'd1;
               slot_in = '0; wacc_in = '0;
               ram_ra = 4'(rnd_ff + 7'd1 - 7'd3);
               if (rnd_ff == 7'd79) begin
                  st_in = ST_FOLD;
               end
            end else begin
               slot_in = slot_ff + 2'd1;
               wacc_in = wacc_ff ^ ram_rd;
               case (slot_ff)
                  2'd0: ram_ra = 4'(rnd_ff - 7'd8);
                  2'd1: ram_ra = 4'(rnd_ff - 7'd14);
                  default: ram_ra = rnd_ff[3:0];
               endcase
            end
            if (rnd_ff == 7'd15 && !(is_sched)) begin
               ram_ra = 4'(7'd16 - 7'd3);
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 5; i++) begin
               ch_in[i] = ch_ff[i] + wk_ff[i];
            end
            rnd_in = '0;
            if (blk_ff == BLK_MSG) begin
               for (int i = 0; i < 5; i++) dig_in[i] = ch_ff[i] + wk_ff[i];
            end
            blk_in = blk_ff + 2'd1;
            st_in = (blk_ff == BLK_DIGEST) ? ST_TRUNC : ST_LOAD;
         end
         ST_TRUNC: begin
            bin_in = {1'b0, dword[30:0]};
            rem_in = '0; dcnt_in = '0;
            st_in = ST_MOD;
         end
         ST_MOD: begin
            case (dcnt_ff)
               7'd0: acc_in = {34'd0, mul_p[63:32]};
               7'd1: rem_in = {32'd0, bin_ff - mul_p[31:0]};
               default: begin
                  if (rem_ff[31:0] >= CM_WORD) begin
                     rem_in = {32'd0, rem_ff[31:0] - CM_WORD};
                  end
                  st_in = ST_OUT;
               end
            endcase
            dcnt_in = dcnt_ff + 7'd1;
         end
         ST_OUT: begin
            code_in = rem_ff[19:0];
            match_in = (rem_ff[31:0] == {12'd0, cand_ff});
            rv_in = 1'b1;
            blk_in = BLK_IPAD;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         rnd_ff <= '0;
         blk_ff <= '0;
         slot_ff <= '0;
         for (int i = 0; i < 5; i++) begin
            ch_ff[i] <= '0; wk_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         rnd_ff <= rnd_in;
         blk_ff <= blk_in;
         slot_ff <= slot_in;
         for (int i = 0; i < 5; i++) begin
            ch_ff[i] <= ch_in[i]; wk_ff[i] <= wk_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      ctr_ff <= ctr_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in; cand_ff <= cand_in;
      wacc_ff <= wacc_in; bin_ff <= bin_in; acc_ff <= acc_in;
      code_ff <= code_in; match_ff <= match_in;
      for (int i = 0; i < 5; i++) dig_ff[i] <= dig_in[i];
   end

   assign req_stall = (st_ff != ST_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_code_matches = match_ff;
   assign rsp_computed_code = code_ff;

   `ASSERT_IMPL(a_rsp_hold, clock, reset, rv_ff && rsp_stall |=> rv_ff && $stable(code_ff))
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, st_ff != ST_IDLE |-> req_stall)
   `ASSERT_IMPL(a_round_range, clock, reset, st_ff == ST_ROUND |-> rnd_ff < 7'd80)
   `ASSERT_IMPL(a_code_range, clock, reset, rv_ff |-> code_ff < 20'd1000000 || CODE_MODULUS > 1000000)
endmodule

/* hdl/otpv_ram.sv */
// Generic single-port-write, one-read synchronous RAM with registered read.
module otpv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
